@@ sv/assert_macros.svh @@
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a property holds at every clock edge outside reset.
`define TEQC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define TEQC_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define TEQC_ASSERT(label, clk, rst, prop, msg)

`define TEQC_NEVER(label, clk, rst, cond, msg)

`endif

`endif

@@ sv/teqc_pkg.sv @@
package teqc_pkg;

   localparam int COORD_W = 12;
   localparam int RAW_W   = 16;

   // request codes
   localparam logic [1:0] REQ_UPDATE = 2'd0;
   localparam logic [1:0] REQ_POLL   = 2'd1;
   localparam logic [1:0] REQ_OPEN   = 2'd2;
   localparam logic [1:0] REQ_CLOSE  = 2'd3;

   // status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_INVALID  = 2'd1;
   localparam logic [1:0] ST_NOT_OPEN = 2'd2;
   localparam logic [1:0] ST_EMPTY    = 2'd3;

   // event kinds
   localparam logic [1:0] KIND_DOWN = 2'd0;
   localparam logic [1:0] KIND_UP   = 2'd1;
   localparam logic [1:0] KIND_MOVE = 2'd2;

   // register indexes
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   typedef struct packed {
      logic [1:0]         kind;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } event_entry_type;

   localparam int ENTRY_W = $bits(event_entry_type);

   typedef struct packed {
      logic [1:0] status;
      logic       pop;
   } ctrl_result_type;

   // Clamp a raw signed coordinate into [0, size-1]; zero when size is zero.
   function automatic logic [COORD_W-1:0] clamp_axis(input logic signed [RAW_W-1:0] raw,
                                                    input logic [COORD_W-1:0] size);
      logic [COORD_W-1:0] res;
      if (size == '0 || raw[RAW_W-1]) begin
         res = '0;
      end else if (raw[RAW_W-2:0] >= {{(RAW_W-1-COORD_W){1'b0}}, size}) begin
         res = size - 1'b1;
      end else begin
         res = raw[COORD_W-1:0];
      end
      return res;
   endfunction

endpackage

@@ sv/touch_event_queue_coalescing.sv @@
// Channel   Direction  Handshake           Payload
// req_      in         req_valid/req_stall req_type, req_pointer_x/y, req_pointer_pressed
// rsp_      out        rsp_valid/rsp_stall rsp_status, rsp_event_kind, rsp_event_x/y
// csr       in/out     psel/penable/pready paddr, pwdata, prdata (width 0x0, height 0x4)
//
// One request per cycle unless the stalled result holds the input: each transfer is held
// in an input register, processed by a clamp per axis, the position compare and one queue access,
// and then lands in the result register, from which its response transfers. The store read
// register loads with the result. Reset is synchronous and clears the queue, the last
// position and the open flag. A stalled result holds the input stage; the input stalls
// only when both are full.
`include "assert_macros.svh"

module touch_event_queue_coalescing #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_type,
   input  logic signed [teqc_pkg::RAW_W-1:0] req_pointer_x,
   input  logic signed [teqc_pkg::RAW_W-1:0] req_pointer_y,
   input  logic                              req_pointer_pressed,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_status,
   output logic [1:0]                        rsp_event_kind,
   output logic [teqc_pkg::COORD_W-1:0]      rsp_event_x,
   output logic [teqc_pkg::COORD_W-1:0]      rsp_event_y,
   // register port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [2:0]                        paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);

   import teqc_pkg::*;

   // screen size registers
   logic [COORD_W-1:0] width_ff, width_in;
   logic [COORD_W-1:0] height_ff, height_in;
   logic               csr_write;

   // input stage
   logic                      s1_valid_ff, s1_valid_in;
   logic [1:0]                s1_type_ff;
   logic signed [RAW_W-1:0]   s1_x_ff, s1_y_ff;
   logic                      s1_pressed_ff;

   // result stage
   logic                s2_valid_ff, s2_valid_in;
   logic [1:0]          s2_status_ff;
   logic                s2_pop_ff;

   logic                s2_load;
   logic                go;
   ctrl_result_type     result;
   event_entry_type     head_entry;

   // ---------------------------------------------------------------------
   // Register port: zero-wait, decode on the word address bit.
   // ---------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         unique case (paddr[2])
            REG_WIDTH:  width_in  = pwdata[COORD_W-1:0];
            REG_HEIGHT: height_in = pwdata[COORD_W-1:0];
            default:    width_in  = width_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_WIDTH:  prdata = {{(32-COORD_W){1'b0}}, width_ff};
         REG_HEIGHT: prdata = {{(32-COORD_W){1'b0}}, height_ff};
         default:    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= '0;
         height_ff <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // ---------------------------------------------------------------------
   // Flow control: the result register loads when empty or drained; the
   // input register advances whenever its item moves on or it is empty.
   // ---------------------------------------------------------------------
   assign s2_load   = !s2_valid_ff || !rsp_stall;
   assign go        = s1_valid_ff && s2_load;
   assign req_stall = s1_valid_ff && !s2_load;

   assign s1_valid_in = req_stall ? s1_valid_ff : req_valid;
   assign s2_valid_in = s2_load ? go : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // capture a new request on every transfer
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_type_ff    <= req_type;
         s1_x_ff       <= req_pointer_x;
         s1_y_ff       <= req_pointer_y;
         s1_pressed_ff <= req_pointer_pressed;
      end
   end

   // hold the status while the result waits
   always_ff @(posedge clock) begin
      if (s2_load) begin
         s2_status_ff <= result.status;
         s2_pop_ff    <= result.pop;
      end
   end

   // ---------------------------------------------------------------------
   // Queue control and event store
   // ---------------------------------------------------------------------
   teqc_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .go              (go),
      .req_type        (s1_type_ff),
      .pointer_x       (s1_x_ff),
      .pointer_y       (s1_y_ff),
      .pointer_pressed (s1_pressed_ff),
      .screen_width    (width_ff),
      .screen_height   (height_ff),
      .result          (result),
      .head_entry      (head_entry)
   );

   // The store's read register loads together with the result stage, so the
   // popped entry lines up with its status. Zero the event fields otherwise.
   assign rsp_valid      = s2_valid_ff;
   assign rsp_status     = s2_status_ff;
   assign rsp_event_kind = s2_pop_ff ? head_entry.kind : 2'd0;
   assign rsp_event_x    = s2_pop_ff ? head_entry.x : '0;
   assign rsp_event_y    = s2_pop_ff ? head_entry.y : '0;

   `TEQC_ASSERT(a_idle_no_stall, clock, reset, !s1_valid_ff |-> !req_stall, "idle input stalls")
   `TEQC_ASSERT(a_s1_moves_on, clock, reset, s1_valid_ff && !rsp_valid |=> rsp_valid, "stuck")
   `TEQC_NEVER(a_pop_ok, clock, reset, s2_pop_ff && s2_status_ff != ST_OK, "error status on pop")

endmodule

@@ sv/teqc_ram.sv @@
module teqc_ram #(
   parameter int WIDTH = 26,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ sv/teqc_ctrl.sv @@
`include "assert_macros.svh"

module teqc_ctrl #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            go,
   input  logic [1:0]                      req_type,
   input  logic signed [teqc_pkg::RAW_W-1:0] pointer_x,
   input  logic signed [teqc_pkg::RAW_W-1:0] pointer_y,
   input  logic                            pointer_pressed,
   input  logic [teqc_pkg::COORD_W-1:0]    screen_width,
   input  logic [teqc_pkg::COORD_W-1:0]    screen_height,
   output teqc_pkg::ctrl_result_type       result,
   output teqc_pkg::event_entry_type       head_entry
);

   import teqc_pkg::*;

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W = IDX_W + 1;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(QUEUE_DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(QUEUE_DEPTH - 1);

   logic [IDX_W-1:0]   head_ff, head_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [COORD_W-1:0] last_x_ff, last_x_in;
   logic [COORD_W-1:0] last_y_ff, last_y_in;
   logic               held_ff, held_in;
   logic               open_ff, open_in;
   logic               tail_move_ff, tail_move_in;

   logic [COORD_W-1:0] cx, cy;
   logic               moved;
   logic [1:0]         push_kind;
   logic [SUM_W-1:0]   tail_sum;
   logic [IDX_W-1:0]   tail_idx, last_idx, head_inc;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   event_entry_type    wr_entry;
   logic [ENTRY_W-1:0] rd_word;

   assign cx       = clamp_axis(pointer_x, screen_width);
   assign cy       = clamp_axis(pointer_y, screen_height);
   assign moved    = (cx != last_x_ff) || (cy != last_y_ff);
   assign push_kind = (pointer_pressed != held_ff) ?
                      (pointer_pressed ? KIND_DOWN : KIND_UP) : KIND_MOVE;

   assign tail_sum = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign tail_idx = (tail_sum >= DEPTH_SUM) ? IDX_W'(tail_sum - DEPTH_SUM)
                                             : IDX_W'(tail_sum);
   assign last_idx = (tail_idx == '0) ? LAST_IDX : tail_idx - 1'b1;
   assign head_inc = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;

   assign wr_entry = '{kind: push_kind, x: cx, y: cy};

   always_comb begin
      head_in      = head_ff;
      count_in     = count_ff;
      last_x_in    = last_x_ff;
      last_y_in    = last_y_ff;
      held_in      = held_ff;
      open_in      = open_ff;
      tail_move_in = tail_move_ff;
      wr_en        = 1'b0;
      wr_addr      = tail_idx;
      result       = '{status: ST_OK, pop: 1'b0};
      if (go) begin
         unique case (req_type)
            REQ_UPDATE: begin
               last_x_in = cx;
               last_y_in = cy;
               held_in   = pointer_pressed;
               if (open_ff && (pointer_pressed != held_ff || moved)) begin
                  wr_en = 1'b1;
                  if (push_kind == KIND_MOVE && count_ff != '0 && tail_move_ff) begin
                     // overwrite the move at the tail
                     wr_addr = last_idx;
                  end else begin
                     tail_move_in = (push_kind == KIND_MOVE);
                     if (count_ff == DEPTH_CNT) begin
                        // drop the oldest; tail lands on the old head
                        head_in = head_inc;
                     end else begin
                        count_in = count_ff + 1'b1;
                     end
                  end
               end
            end
            REQ_POLL: begin
               if (!open_ff) begin
                  result.status = ST_NOT_OPEN;
               end else if (count_ff == '0) begin
                  result.status = ST_EMPTY;
               end else begin
                  result.pop = 1'b1;
                  head_in    = head_inc;
                  count_in   = count_ff - 1'b1;
               end
            end
            REQ_OPEN: begin
               if (screen_width == '0 || screen_height == '0) begin
                  result.status = ST_INVALID;
               end else begin
                  head_in  = '0;
                  count_in = '0;
                  open_in  = 1'b1;
               end
            end
            REQ_CLOSE: begin
               open_in  = 1'b0;
               held_in  = 1'b0;
               head_in  = '0;
               count_in = '0;
            end
            default: begin
               open_in = open_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         last_x_ff    <= '0;
         last_y_ff    <= '0;
         held_ff      <= 1'b0;
         open_ff      <= 1'b0;
         tail_move_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         last_x_ff    <= last_x_in;
         last_y_ff    <= last_y_in;
         held_ff      <= held_in;
         open_ff      <= open_in;
         tail_move_ff <= tail_move_in;
      end
   end

   teqc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (go),
      .rd_addr (head_ff),
      .rd_data (rd_word)
   );

   assign head_entry = event_entry_type'(rd_word);

   `TEQC_ASSERT(a_count_le_depth, clock, reset, count_ff <= DEPTH_CNT, "queue count above depth")
   `TEQC_ASSERT(a_head_in_range, clock, reset, head_ff <= LAST_IDX, "queue head out of range")
   `TEQC_ASSERT(a_closed_empty, clock, reset, !open_ff |-> count_ff == '0, "closed queue not empty")

endmodule

@@ tb/sv/touch_queue_monitor.sv @@
`timescale 1ns / 1ps

module touch_queue_monitor #(
   parameter int DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic [1:0]                        req_type,
   input  logic signed [teqc_pkg::RAW_W-1:0] req_pointer_x,
   input  logic signed [teqc_pkg::RAW_W-1:0] req_pointer_y,
   input  logic                              req_pointer_pressed,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [1:0]                        rsp_status,
   input  logic [1:0]                        rsp_event_kind,
   input  logic [teqc_pkg::COORD_W-1:0]      rsp_event_x,
   input  logic [teqc_pkg::COORD_W-1:0]      rsp_event_y,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic                              pready,
   input  logic [2:0]                        paddr,
   input  logic [31:0]                       pwdata,
   output int                                pending,
   output int                                failures
);
   import teqc_pkg::*;

   typedef struct packed {
      logic [1:0]         status;
      logic [1:0]         kind;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } touch_response_type;

   event_entry_type    ring [DEPTH];
   int                 ring_head;
   int                 ring_count;
   logic [COORD_W-1:0] pos_x, pos_y;
   logic [COORD_W-1:0] screen_w, screen_h;
   logic               pen_held;
   logic               queue_open;
   touch_response_type expected_responses [$];
   int                 fail_count = 0;

   function automatic logic [COORD_W-1:0] fit_axis(logic signed [RAW_W-1:0] raw,
                                                   logic [COORD_W-1:0] size);
      if (size == '0 || raw < 0) return '0;
      if (int'(raw) > int'(size) - 1) return size - 1'b1;
      return raw[COORD_W-1:0];
   endfunction

   // Coalesce a move onto a move at the tail; drop the oldest entry when full.
   function automatic void queue_event(logic [1:0] kind, logic [COORD_W-1:0] x,
                                       logic [COORD_W-1:0] y);
      int tail_idx;
      if (ring_count > 0 && kind == KIND_MOVE) begin
         tail_idx = (ring_head + ring_count - 1) % DEPTH;
         if (ring[tail_idx].kind == KIND_MOVE) begin
            ring[tail_idx] = '{kind: kind, x: x, y: y};
            return;
         end
      end
      if (ring_count >= DEPTH) begin
         ring_head = (ring_head + 1) % DEPTH;
         ring_count = DEPTH - 1;
      end
      ring[(ring_head + ring_count) % DEPTH] = '{kind: kind, x: x, y: y};
      ring_count++;
   endfunction

   function automatic touch_response_type predict_response(logic [1:0] code,
                                                           logic signed [RAW_W-1:0] raw_x,
                                                           logic signed [RAW_W-1:0] raw_y,
                                                           logic pressed);
      touch_response_type res;
      logic [COORD_W-1:0] cx, cy;
      logic               moved;
      res = '0;
      res.status = ST_OK;
      case (code)
         REQ_UPDATE: begin
            cx = fit_axis(raw_x, screen_w);
            cy = fit_axis(raw_y, screen_h);
            moved = (cx != pos_x) || (cy != pos_y);
            pos_x = cx;
            pos_y = cy;
            if (queue_open) begin
               if (pressed != pen_held) queue_event(pressed ? KIND_DOWN : KIND_UP, cx, cy);
               else if (moved) queue_event(KIND_MOVE, cx, cy);
            end
            pen_held = pressed;
         end
         REQ_POLL: begin
            if (!queue_open) begin
               res.status = ST_NOT_OPEN;
            end else if (ring_count == 0) begin
               res.status = ST_EMPTY;
            end else begin
               res.kind = ring[ring_head].kind;
               res.x = ring[ring_head].x;
               res.y = ring[ring_head].y;
               ring_head = (ring_head + 1) % DEPTH;
               ring_count--;
            end
         end
         REQ_OPEN: begin
            if (screen_w == '0 || screen_h == '0) begin
               res.status = ST_INVALID;
            end else begin
               ring_head = 0;
               ring_count = 0;
               queue_open = 1'b1;
            end
         end
         default: begin
            queue_open = 1'b0;
            pen_held = 1'b0;
            ring_head = 0;
            ring_count = 0;
         end
      endcase
      return res;
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      touch_response_type want;
      if (reset) begin
         ring_head = 0;
         ring_count = 0;
         pos_x = '0;
         pos_y = '0;
         screen_w = '0;
         screen_h = '0;
         pen_held = 1'b0;
         queue_open = 1'b0;
         expected_responses.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_WIDTH) screen_w = pwdata[COORD_W-1:0];
            else screen_h = pwdata[COORD_W-1:0];
         end
         if (req_valid && !req_stall)
            expected_responses.push_back(predict_response(req_type, req_pointer_x,
                                                          req_pointer_y, req_pointer_pressed));
         if (rsp_valid && !rsp_stall) begin
            if (expected_responses.size() == 0) begin
               $error("rsp transfer with no request outstanding");
               fail_count++;
            end else begin
               want = expected_responses.pop_front();
               check_field("rsp_status", int'(want.status), int'(rsp_status));
               check_field("rsp_event_kind", int'(want.kind), int'(rsp_event_kind));
               check_field("rsp_event_x", int'(want.x), int'(rsp_event_x));
               check_field("rsp_event_y", int'(want.y), int'(rsp_event_y));
            end
         end
      end
      pending <= expected_responses.size();
      failures <= fail_count;
   end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import teqc_pkg::*;

   localparam int DEPTH           = 16;
   localparam int HOLD_OFF_CYCLES = 150;
   localparam int SETTLE_CYCLES   = 4;
   localparam int DRAIN_CYCLES    = 8;
   localparam int CYCLE_LIMIT     = 400000;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [1:0]               req_type = REQ_UPDATE;
   logic signed [RAW_W-1:0]  req_pointer_x = '0;
   logic signed [RAW_W-1:0]  req_pointer_y = '0;
   logic                     req_pointer_pressed = 1'b0;

   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [1:0]               rsp_status;
   logic [1:0]               rsp_event_kind;
   logic [COORD_W-1:0]       rsp_event_x;
   logic [COORD_W-1:0]       rsp_event_y;

   logic                     psel = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite = 1'b0;
   logic [2:0]               paddr = '0;
   logic [31:0]              pwdata = '0;
   logic [31:0]              prdata;
   logic                     pready;

   int                       pending;
   int                       failures;

   // Shared knobs between the request driver and the response staller.
   bit                       idle_enable = 1'b0;
   bit                       hold_off_start = 1'b0;
   int unsigned              stall_left = 0;
   int unsigned              cycle_count = 0;

   // Pointer track for the generator: raw aim point and button level.
   int                       screen_w_now = 0;
   int                       screen_h_now = 0;
   logic signed [RAW_W-1:0]  aim_x = '0;
   logic signed [RAW_W-1:0]  aim_y = '0;
   logic                     pen_down = 1'b0;

   always #6 clock = ~clock;

   touch_event_queue_coalescing #(
      .QUEUE_DEPTH(DEPTH)
   ) dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_type, .req_pointer_x, .req_pointer_y,
      .req_pointer_pressed,
      .rsp_valid, .rsp_stall, .rsp_status, .rsp_event_kind, .rsp_event_x, .rsp_event_y,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   touch_queue_monitor #(
      .DEPTH(DEPTH)
   ) monitor (
      .clock, .reset,
      .req_valid, .req_stall, .req_type, .req_pointer_x, .req_pointer_y,
      .req_pointer_pressed,
      .rsp_valid, .rsp_stall, .rsp_status, .rsp_event_kind, .rsp_event_x, .rsp_event_y,
      .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
      .pending, .failures
   );

   // Response side: random stall bursts while idling is on, plus one long
   // hold-off on request so the block backs up into its input. Count the
   // hold-off here and drive rsp_stall once per edge.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_off_start) begin
            hold_off_start = 1'b0;
            stall_left = HOLD_OFF_CYCLES;
         end else if (stall_left == 0 && idle_enable && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 18);
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: give up on a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Offer one request and hold it until the transfer happens. Optionally
   // drop valid for a random gap first; valid is never lowered and raised
   // within the same edge.
   task automatic send_request(logic [1:0] code, logic signed [RAW_W-1:0] px,
                               logic signed [RAW_W-1:0] py, logic pressed);
      if (idle_enable && $urandom_range(0, 6) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= code;
      req_pointer_x <= px;
      req_pointer_y <= py;
      req_pointer_pressed <= pressed;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid, wait for every outstanding response, then let the pipe empty.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Setup cycle, access cycle, then release the bus. Put junk in the upper
   // data bits; only the low 12 bits belong to the register.
   task automatic csr_write(logic reg_idx, int value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {reg_idx, 2'b00};
      pwdata <= {20'($urandom), 12'(value)};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [RAW_W-1:0] boundary_coord(int size);
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return -16'sd1;
         2: return 16'sd0;
         3: return 16'sh7fff;
         4: return 16'(size - 1);
         default: return 16'(size);
      endcase
   endfunction

   // Pointer updates that mostly wander around the last position, so moves
   // coalesce and press edges break them up; polls, opens and closes mixed in.
   task automatic random_request(int poll_weight, int toggle_odds);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < poll_weight) begin
         send_request(REQ_POLL, 16'($urandom), 16'($urandom), 1'($urandom));
      end else if (pick < poll_weight + 4) begin
         send_request(REQ_OPEN, 16'($urandom), 16'($urandom), 1'($urandom));
      end else if (pick < poll_weight + 6) begin
         send_request(REQ_CLOSE, 16'($urandom), 16'($urandom), 1'($urandom));
      end else begin
         if ($urandom_range(0, 99) < toggle_odds) pen_down = ~pen_down;
         case ($urandom_range(0, 9))
            6: ;
            7: begin
               aim_x = 16'($urandom);
               aim_y = 16'($urandom);
            end
            8: begin
               aim_x = boundary_coord(screen_w_now);
               aim_y = boundary_coord(screen_h_now);
            end
            9: begin
               aim_x = 16'($urandom_range(0, screen_w_now));
               aim_y = 16'($urandom_range(0, screen_h_now));
            end
            default: begin
               aim_x = aim_x + 16'($urandom_range(0, 8)) - 16'd4;
               aim_y = aim_y + 16'($urandom_range(0, 8)) - 16'd4;
            end
         endcase
         send_request(REQ_UPDATE, aim_x, aim_y, pen_down);
      end
   endtask

   initial begin
      int w_list [5];
      int h_list [5];
      int poll_weight;
      int toggle_odds;

      // Screen settings per random phase: full size, one pixel, random,
      // zero width (opens refused), and a tiny screen run without idling.
      w_list = '{4095, 1, 0, 0, 13};
      h_list = '{4095, 1, 0, 300, 7};
      w_list[2] = $urandom_range(1, 4095);
      h_list[2] = $urandom_range(1, 4095);
      poll_weight = 25;
      toggle_odds = 25;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      idle_enable = 1'b1;

      // Closed block with zero-sized screen: poll refused, open refused,
      // update clamps to zero and queues nothing, close is harmless.
      send_request(REQ_POLL, 16'sd0, 16'sd0, 1'b0);
      send_request(REQ_OPEN, 16'sd0, 16'sd0, 1'b0);
      send_request(REQ_UPDATE, 16'sh7fff, -16'sd5, 1'b1);
      send_request(REQ_CLOSE, 16'sd0, 16'sd0, 1'b0);

      // Open with only one dimension set is still refused.
      settle();
      csr_write(REG_WIDTH, 640);
      csr_write(REG_HEIGHT, 0);
      send_request(REQ_OPEN, 16'sd0, 16'sd0, 1'b0);
      settle();
      csr_write(REG_HEIGHT, 480);

      // Open, then walk clamped press, clamped repeat, move, coalesced move, release,
      // move with the button up; drain and hit the empty case.
      send_request(REQ_OPEN, 16'sd0, 16'sd0, 1'b0);
      send_request(REQ_POLL, 16'sd0, 16'sd0, 1'b0);
      send_request(REQ_UPDATE, 16'h8000, 16'sh7fff, 1'b1);
      send_request(REQ_UPDATE, -16'sd1, 16'sd500, 1'b1);
      send_request(REQ_UPDATE, 16'sd100, 16'sd200, 1'b1);
      send_request(REQ_UPDATE, 16'sd639, 16'sd479, 1'b1);
      send_request(REQ_UPDATE, 16'sd640, 16'sd480, 1'b0);
      send_request(REQ_UPDATE, 16'sd640, 16'sd480, 1'b0);
      send_request(REQ_UPDATE, 16'sd5, 16'sd5, 1'b0);
      repeat (5) send_request(REQ_POLL, 16'sd0, 16'sd0, 1'b0);

      // Reopen while open flushes the queue; close flushes and refuses polls.
      send_request(REQ_UPDATE, 16'sd7, 16'sd7, 1'b1);
      send_request(REQ_OPEN, 16'sd0, 16'sd0, 1'b0);
      send_request(REQ_POLL, 16'sd0, 16'sd0, 1'b0);
      send_request(REQ_UPDATE, 16'sd8, 16'sd8, 1'b0);
      send_request(REQ_CLOSE, 16'sd0, 16'sd0, 1'b0);
      send_request(REQ_POLL, 16'sd0, 16'sd0, 1'b0);

      for (int p = 0; p < 5; p++) begin
         settle();
         csr_write(REG_WIDTH, w_list[p]);
         csr_write(REG_HEIGHT, h_list[p]);
         screen_w_now = w_list[p];
         screen_h_now = h_list[p];
         send_request(REQ_OPEN, 16'sd0, 16'sd0, 1'b0);
         for (int n = 0; n < 80; n++) begin
            // Re-pick the traffic mix every 20 transfers: fill (rare polls,
            // busy button), balanced, or drain-heavy.
            if (n % 20 == 0) begin
               case ($urandom_range(0, 2))
                  0: begin
                     poll_weight = 2;
                     toggle_odds = 50;
                  end
                  1: begin
                     poll_weight = 25;
                     toggle_odds = 25;
                  end
                  default: begin
                     poll_weight = 50;
                     toggle_odds = 15;
                  end
               endcase
               idle_enable = (p < 4) && ($urandom_range(0, 3) != 0);
            end
            // Back-pressure: hold responses off and keep offering requests.
            if (p == 0 && n == 40) begin
               hold_off_start = 1'b1;
               idle_enable = 1'b0;
            end
            random_request(poll_weight, toggle_odds);
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
